// ===== rtl/flr_pkg.sv =====
`default_nettype none

package flr_pkg;

   localparam int COORD_BITS    = 10;
   localparam int COLOR_BITS    = 24;
   localparam int ADDR_BITS     = 22;
   localparam int PITCH_BITS    = 11;
   localparam int BPP_BITS      = 2;
   localparam int FRAC_BITS     = 6;
   localparam int QUO_BITS      = FRAC_BITS + 1;
   localparam int SLOPE_BITS    = QUO_BITS + 1;
   localparam int ACC_BITS      = COORD_BITS + SLOPE_BITS;
   localparam int PROD_BITS     = COORD_BITS + PITCH_BITS;
   localparam int REQ_DATA_BITS = 4 * COORD_BITS + COLOR_BITS;
   localparam int RSP_FIELD_BITS = 2 * COORD_BITS + ADDR_BITS + COLOR_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int CSR_INDEX_BITS = 1;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [PITCH_BITS-1:0] ROW_PITCH_RESET       = PITCH_BITS'(752);
   localparam logic [BPP_BITS-1:0]   BYTES_PER_PIXEL_RESET = BPP_BITS'(1);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_PITCH       = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYTES_PER_PIXEL = 1'b1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [1:0] {
      FE_ACCEPT,
      FE_DIVIDE,
      FE_PUSH
   } front_state_type;

   typedef enum logic {
      ENT_LINE,
      ENT_TICK
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type          kind;
      logic                    draw;
      logic                    x_is_major;
      logic                    major_descending;
      logic [COORD_BITS-1:0]   origin_x;
      logic [COORD_BITS-1:0]   origin_y;
      logic [COORD_BITS-1:0]   major_length;
      logic [SLOPE_BITS-1:0]   slope_q6;
      logic [COLOR_BITS-1:0]   color;
   } line_entry_type;

   typedef struct packed {
      logic [PITCH_BITS-1:0] row_pitch;
      logic [BPP_BITS-1:0]   bytes_per_pixel;
   } csr_type;

endpackage

`default_nettype wire

// ===== rtl/flr_front.sv =====
`default_nettype none

module flr_front
   import flr_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                     req_tuser,
   input  wire logic                     queue_full,
   output logic                          push,
   output line_entry_type                push_entry
);

   localparam logic [2:0] DIV_LAST = 3'(QUO_BITS - 1);

   front_state_type state_ff, state_in;

   logic [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
   logic [COLOR_BITS-1:0] draw_color;
   logic [COORD_BITS-1:0] dx, dy;
   logic                  accept, load;

   logic [COORD_BITS-1:0] origin_x_ff, origin_y_ff, len_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic                  x_major_ff, major_desc_ff, minor_desc_ff, draw_ff;
   logic [COORD_BITS:0]   rem_ff;
   logic [QUO_BITS-1:0]   quo_ff;
   logic [2:0]            cnt_ff;

   logic                  quo_bit;
   logic [COORD_BITS:0]   rem_diff;
   logic [SLOPE_BITS-1:0] quo_ext;

   assign start_x    = req_tdata[COORD_BITS-1:0];
   assign start_y    = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign end_x      = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign end_y      = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
   assign draw_color = req_tdata[REQ_DATA_BITS-1:4*COORD_BITS];

   assign dx = (start_x > end_x) ? start_x - end_x : end_x - start_x;
   assign dy = (start_y > end_y) ? start_y - end_y : end_y - start_y;

   assign accept = req_tvalid && req_tready;
   assign load   = accept && (req_tuser == OP_LOAD);

   // one quotient bit per cycle, weight 64 first
   assign quo_bit  = (rem_ff >= {1'b0, len_ff});
   assign rem_diff = quo_bit ? rem_ff - {1'b0, len_ff} : rem_ff;
   assign quo_ext  = {1'b0, quo_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FE_ACCEPT: begin
            if (load) state_in = FE_DIVIDE;
         end
         FE_DIVIDE: begin
            if (cnt_ff == DIV_LAST) state_in = FE_PUSH;
         end
         FE_PUSH: begin
            if (!queue_full) state_in = FE_ACCEPT;
         end
         default: state_in = FE_ACCEPT;
      endcase
   end

   always_comb begin
      req_tready                  = 1'b0;
      push                        = 1'b0;
      push_entry.kind             = ENT_LINE;
      push_entry.draw             = draw_ff;
      push_entry.x_is_major       = x_major_ff;
      push_entry.major_descending = major_desc_ff;
      push_entry.origin_x         = origin_x_ff;
      push_entry.origin_y         = origin_y_ff;
      push_entry.major_length     = len_ff;
      push_entry.slope_q6         = minor_desc_ff ? SLOPE_BITS'(0) - quo_ext : quo_ext;
      push_entry.color            = color_ff;
      case (state_ff)
         FE_ACCEPT: begin
            req_tready = !queue_full;
            // ticks go straight to the queue
            if (accept && (req_tuser == OP_TICK)) begin
               push            = 1'b1;
               push_entry.kind = ENT_TICK;
            end
         end
         FE_DIVIDE: begin
         end
         FE_PUSH: begin
            push = !queue_full;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_ACCEPT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            cnt_ff <= '0;
         end else if (state_ff == FE_DIVIDE) begin
            cnt_ff <= cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         origin_x_ff <= start_x;
         origin_y_ff <= start_y;
         color_ff    <= draw_color;
         draw_ff     <= (dx != '0) || (dy != '0);
         quo_ff      <= '0;
         if (dx > dy) begin
            x_major_ff    <= 1'b1;
            len_ff        <= dx;
            major_desc_ff <= end_x < start_x;
            minor_desc_ff <= end_y < start_y;
            rem_ff        <= {1'b0, dy};
         end else begin
            x_major_ff    <= 1'b0;
            len_ff        <= dy;
            major_desc_ff <= end_y < start_y;
            minor_desc_ff <= end_x < start_x;
            rem_ff        <= {1'b0, dx};
         end
      end else if (state_ff == FE_DIVIDE) begin
         quo_ff <= {quo_ff[QUO_BITS-2:0], quo_bit};
         rem_ff <= {rem_diff[COORD_BITS-1:0], 1'b0};
      end
   end

endmodule

`default_nettype wire

// ===== rtl/flr_queue.sv =====
`default_nettype none

module flr_queue
   import flr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire line_entry_type push_entry,
   output logic                full,
   input  wire logic           pop,
   output line_entry_type      pop_entry,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   line_entry_type     slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);
   assign pop_entry = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

// ===== rtl/flr_back.sv =====
`default_nettype none

module flr_back
   import flr_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire csr_type                  csr,
   input  wire logic                     queue_empty,
   input  wire line_entry_type           pop_entry,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                          rsp_tlast
);

   logic advance, take_tick;

   // line state
   logic                         active_ff, x_major_ff, desc_ff;
   logic [COORD_BITS-1:0]        step_ff, len_ff, org_x_ff, org_y_ff;
   logic [SLOPE_BITS-1:0]        slope_ff;
   logic signed [ACC_BITS-1:0]   acc_ff;
   logic [COLOR_BITS-1:0]        color_ff;

   logic [COORD_BITS-1:0] maj_org, min_org, maj, mnr, off, px_in, py_in;
   logic                  last_in;

   // stage 1: coordinates
   logic                  s1_valid_ff, s1_last_ff;
   logic [COORD_BITS-1:0] s1_px_ff, s1_py_ff;
   logic [COLOR_BITS-1:0] s1_color_ff;

   // stage 2: row product
   logic                  s2_valid_ff, s2_last_ff;
   logic [COORD_BITS-1:0] s2_px_ff;
   logic [PROD_BITS-1:0]  s2_prod_ff, prod_in;
   logic [COLOR_BITS-1:0] s2_color_ff;

   // output register
   logic                  out_valid_ff, out_last_ff;
   logic [COORD_BITS-1:0] out_px_ff, out_py_ff;
   logic [ADDR_BITS-1:0]  out_addr_ff, sum, addr_in;
   logic [COLOR_BITS-1:0] out_color_ff;
   logic [COORD_BITS-1:0] out_py_pipe_ff, s2_py_ff;

   assign advance   = !out_valid_ff || rsp_tready;
   assign pop       = advance && !queue_empty;
   assign take_tick = pop && (pop_entry.kind == ENT_TICK) && active_ff;

   assign maj_org = x_major_ff ? org_x_ff : org_y_ff;
   assign min_org = x_major_ff ? org_y_ff : org_x_ff;
   assign maj     = desc_ff ? maj_org - step_ff : maj_org + step_ff;
   // floor of acc/64 by arithmetic shift, wrapped to the coordinate width
   assign off     = acc_ff[FRAC_BITS +: COORD_BITS];
   assign mnr     = min_org + off;
   assign px_in   = x_major_ff ? maj : mnr;
   assign py_in   = x_major_ff ? mnr : maj;
   assign last_in = (step_ff == len_ff);

   assign prod_in = PROD_BITS'(s1_py_ff) * PROD_BITS'(csr.row_pitch);

   assign sum     = ADDR_BITS'(s2_px_ff) + ADDR_BITS'(s2_prod_ff);
   assign addr_in = (csr.bytes_per_pixel[0] ? sum : '0)
                  + (csr.bytes_per_pixel[1] ? {sum[ADDR_BITS-2:0], 1'b0} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= '0;
         acc_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= take_tick;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
         if (pop && (pop_entry.kind == ENT_LINE)) begin
            // a new line drops whatever was being drawn
            active_ff <= pop_entry.draw;
            step_ff   <= '0;
            acc_ff    <= '0;
         end else if (take_tick) begin
            if (last_in) begin
               active_ff <= 1'b0;
               step_ff   <= '0;
            end else begin
               step_ff <= step_ff + 1'b1;
               acc_ff  <= acc_ff + ACC_BITS'($signed(slope_ff));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (pop && (pop_entry.kind == ENT_LINE)) begin
            x_major_ff <= pop_entry.x_is_major;
            desc_ff    <= pop_entry.major_descending;
            len_ff     <= pop_entry.major_length;
            org_x_ff   <= pop_entry.origin_x;
            org_y_ff   <= pop_entry.origin_y;
            slope_ff   <= pop_entry.slope_q6;
            color_ff   <= pop_entry.color;
         end
         s1_px_ff       <= px_in;
         s1_py_ff       <= py_in;
         s1_last_ff     <= last_in;
         s1_color_ff    <= color_ff;
         s2_px_ff       <= s1_px_ff;
         s2_py_ff       <= s1_py_ff;
         s2_prod_ff     <= prod_in;
         s2_last_ff     <= s1_last_ff;
         s2_color_ff    <= s1_color_ff;
         out_px_ff      <= s2_px_ff;
         out_py_pipe_ff <= s2_py_ff;
         out_addr_ff    <= addr_in;
         out_color_ff   <= s2_color_ff;
         out_last_ff    <= s2_last_ff;
      end
   end

   assign out_py_ff  = out_py_pipe_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({out_color_ff, out_addr_ff, out_py_ff, out_px_ff});

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (step_ff <= len_ff))
      else $error("step count ran past the major length");

   a_idle_tick_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && pop && (pop_entry.kind == ENT_TICK) && !active_ff) |=> !s1_valid_ff)
      else $error("tick on an idle line produced a pixel");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (advance && take_tick && last_in) |=> !active_ff)
      else $error("line still active after its last pixel");

endmodule

`default_nettype wire

// ===== rtl/fixed_point_line_rasterizer.sv =====
// A tick request gives its pixel on rsp through the queue, stage 1, stage 2 and the output register.
// Throughput: ticks one per cycle while the queue has room; a line load steps through
// accept, a bit-serial slope divider and a queue push, and holds req_tready low after the accept.
// A stalled rsp backs up the 3-stage pixel pipe and then the request queue.
// Reset (synchronous, active high): no line active, queue empty,
// row_pitch = 752, bytes_per_pixel = 1.
`default_nettype none

module fixed_point_line_rasterizer
   import flr_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // start_x, start_y, end_x, end_y, draw_color
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,
   // opcode
   input  wire logic                      req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // pixel_x, pixel_y, byte_address, pixel_color, zero pad
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic                           rsp_tlast,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [PITCH_BITS-1:0]     csr_data
);

   csr_type        csr_ff;
   logic           queue_full, queue_empty, push, pop;
   line_entry_type push_entry, pop_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.row_pitch       <= ROW_PITCH_RESET;
         csr_ff.bytes_per_pixel <= BYTES_PER_PIXEL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROW_PITCH:       csr_ff.row_pitch       <= csr_data;
            CSR_BYTES_PER_PIXEL: csr_ff.bytes_per_pixel <= csr_data[BPP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   flr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   flr_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   flr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .queue_empty (queue_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== dv/line_pixel_checker.sv =====
`timescale 1ns / 1ps

module line_pixel_checker
   import flr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,
   input  wire logic                      req_tuser,
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input  wire logic                      rsp_tlast,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [PITCH_BITS-1:0]     csr_data,
   output int                             fail_count,
   output int                             pending
);

   localparam int MAX_PRINTED = 40;

   typedef struct {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [ADDR_BITS-1:0]  addr;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_type;

   pixel_type expected_pixels[$];

   // shadow of the line walker and its registers
   logic                  drawing;
   logic [PITCH_BITS:0]   step;
   logic [COORD_BITS-1:0] span;
   logic                  x_major;
   logic                  descending;
   logic [COORD_BITS-1:0] org_x;
   logic [COORD_BITS-1:0] org_y;
   int                    slope;
   logic [COLOR_BITS-1:0] line_color;
   logic [PITCH_BITS-1:0] pitch;
   logic [BPP_BITS-1:0]   bpp;

   int failures = 0;
   int pixel_index = 0;

   task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      failures++;
      if (failures <= MAX_PRINTED) begin
         $display("%0t pixel %0d: %s got %0h expected %0h", $realtime, pixel_index, what,
                  got, want);
      end
   endtask

   function int line_slope(input int from, input int to, input int len);
      int mag;
      mag = ((from > to) ? from - to : to - from) * 64 / len;
      return (to < from) ? -mag : mag;
   endfunction

   task rasterize_request(input logic op, input logic [REQ_DATA_BITS-1:0] data);
      logic [COORD_BITS-1:0] sx, sy, ex, ey, major_pos, minor_pos, px, py;
      int                    dx, dy, offset;
      logic [63:0]           address;
      pixel_type             pix;
      if (op == OP_LOAD) begin
         sx = data[COORD_BITS-1:0];
         sy = data[2*COORD_BITS-1:COORD_BITS];
         ex = data[3*COORD_BITS-1:2*COORD_BITS];
         ey = data[4*COORD_BITS-1:3*COORD_BITS];
         dx = (sx > ex) ? sx - ex : ex - sx;
         dy = (sy > ey) ? sy - ey : ey - sy;
         org_x = sx;
         org_y = sy;
         line_color = data[REQ_DATA_BITS-1:4*COORD_BITS];
         step = '0;
         if (dx == 0 && dy == 0) begin
            drawing = 1'b0;
         end else begin
            x_major = dx > dy;
            if (x_major) begin
               span = COORD_BITS'(dx);
               descending = ex < sx;
               slope = line_slope(sy, ey, dx);
            end else begin
               span = COORD_BITS'(dy);
               descending = ey < sy;
               slope = line_slope(sx, ex, dy);
            end
            drawing = 1'b1;
         end
      end else if (drawing) begin
         // arithmetic shift floors the signed minor offset
         offset = (int'(step) * slope) >>> 6;
         major_pos = x_major ? org_x : org_y;
         minor_pos = x_major ? org_y : org_x;
         major_pos = descending ? major_pos - step[COORD_BITS-1:0]
                                : major_pos + step[COORD_BITS-1:0];
         minor_pos = minor_pos + offset[COORD_BITS-1:0];
         px = x_major ? major_pos : minor_pos;
         py = x_major ? minor_pos : major_pos;
         address = (64'(px) + 64'(py) * 64'(pitch)) * 64'(bpp);
         pix.x = px;
         pix.y = py;
         pix.addr = address[ADDR_BITS-1:0];
         pix.color = line_color;
         pix.last = step >= span;
         expected_pixels.push_back(pix);
         if (pix.last) begin
            drawing = 1'b0;
            step = '0;
         end else begin
            step = step + 1'b1;
         end
      end
   endtask

   task check_pixel();
      pixel_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch("unexpected pixel at x", rsp_tdata[COORD_BITS-1:0], '0);
      end else begin
         want = expected_pixels.pop_front();
         if (rsp_tdata[COORD_BITS-1:0] !== want.x)
            report_mismatch("pixel_x", rsp_tdata[COORD_BITS-1:0], want.x);
         if (rsp_tdata[2*COORD_BITS-1:COORD_BITS] !== want.y)
            report_mismatch("pixel_y", rsp_tdata[2*COORD_BITS-1:COORD_BITS], want.y);
         if (rsp_tdata[2*COORD_BITS+ADDR_BITS-1:2*COORD_BITS] !== want.addr)
            report_mismatch("byte_address",
                            rsp_tdata[2*COORD_BITS+ADDR_BITS-1:2*COORD_BITS], want.addr);
         if (rsp_tdata[RSP_FIELD_BITS-1:2*COORD_BITS+ADDR_BITS] !== want.color)
            report_mismatch("pixel_color",
                            rsp_tdata[RSP_FIELD_BITS-1:2*COORD_BITS+ADDR_BITS], want.color);
         if (rsp_tlast !== want.last)
            report_mismatch("last_pixel", rsp_tlast, want.last);
      end
      pixel_index++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         drawing = 1'b0;
         step = '0;
         span = '0;
         x_major = 1'b0;
         descending = 1'b0;
         org_x = '0;
         org_y = '0;
         slope = 0;
         line_color = '0;
         pitch = ROW_PITCH_RESET;
         bpp = BYTES_PER_PIXEL_RESET;
         expected_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_pixel();
         if (req_tvalid && req_tready)
            rasterize_request(req_tuser, req_tdata);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_PITCH:       pitch = csr_data;
               CSR_BYTES_PER_PIXEL: bpp = csr_data[BPP_BITS-1:0];
               default: ;
            endcase
         end
      end
      pending <= expected_pixels.size();
      fail_count <= failures;
   end

endmodule

// ===== dv/fixed_point_line_rasterizer_tb.sv =====
`timescale 1ns / 1ps

module fixed_point_line_rasterizer_tb;
   import flr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int ITEM_TARGET    = 1150;
   localparam int PHASES         = 6;
   localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                      req_tuser = OP_LOAD;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_ROW_PITCH;
   logic [PITCH_BITS-1:0]     csr_data = '0;

   int   failures;
   int   pending;
   int   items_sent = 0;
   int   cycle_count = 0;
   int   idle_cycles = 0;
   int   ready_hold = 0;
   logic steady = 1'b0;

   fixed_point_line_rasterizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   line_pixel_checker pixel_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (failures),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60)
         return 0;
      if (roll < 94)
         return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // watchdog, plus stretches where neither side idles
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      steady <= (cycle_count % 1500) < 250;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else if (!rsp_tready || $urandom_range(0, 3) != 0) begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b0;
         ready_hold <= pick_pause();
      end
   end

   task automatic send_request(input logic op, input logic [REQ_DATA_BITS-1:0] data);
      int pause;
      pause = pick_pause();
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      items_sent += 1;
   endtask

   task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [COLOR_BITS-1:0] color, input int ticks);
      send_request(OP_LOAD, {color, COORD_BITS'(ey), COORD_BITS'(ex), COORD_BITS'(sy),
                             COORD_BITS'(sx)});
      for (int i = 0; i < ticks; i++)
         send_request(OP_TICK, {$urandom, $urandom});
   endtask

   function automatic int reflect_end(input int start, input int delta);
      int e;
      e = start + delta;
      if (e < 0 || e > COORD_MAX)
         e = start - delta;
      return e;
   endfunction

   task automatic random_line();
      int roll, sx, sy, ex, ey, d, span, ticks;
      logic [COLOR_BITS-1:0] color;
      roll = $urandom_range(0, 99);
      sx = $urandom_range(0, COORD_MAX);
      sy = $urandom_range(0, COORD_MAX);
      color = $urandom;
      if (roll < 70) begin
         ex = reflect_end(sx, int'($urandom_range(0, 48)) - 24);
         ey = reflect_end(sy, int'($urandom_range(0, 48)) - 24);
         span = (sx > ex) ? sx - ex : ex - sx;
         d = (sy > ey) ? sy - ey : ey - sy;
         if (d > span)
            span = d;
         d = $urandom_range(0, 99);
         if (d < 15)
            ticks = $urandom_range(0, span);
         else if (d < 25)
            ticks = span + 1 + $urandom_range(1, 3);
         else
            ticks = span + 1;
         send_line(sx, sy, ex, ey, color, ticks);
      end else if (roll < 80) begin
         // long line: mostly dropped early by the next load
         ex = $urandom_range(0, COORD_MAX);
         ey = $urandom_range(0, COORD_MAX);
         ticks = ($urandom_range(0, 24) == 0) ? COORD_MAX + 1 : $urandom_range(1, 30);
         send_line(sx, sy, ex, ey, color, ticks);
      end else if (roll < 88) begin
         send_line(sx, sy, sx, sy, color, $urandom_range(0, 3));
      end else if (roll < 94) begin
         // equal deltas on both axes
         d = $urandom_range(1, 20);
         ex = reflect_end(sx, $urandom_range(0, 1) ? d : -d);
         ey = reflect_end(sy, $urandom_range(0, 1) ? d : -d);
         send_line(sx, sy, ex, ey, color, d + 1);
      end else begin
         repeat ($urandom_range(1, 4))
            send_request(OP_TICK, {$urandom, $urandom});
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [PITCH_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input int pitch, input int bpp);
      logic [PITCH_BITS-1:0] value;
      value = PITCH_BITS'($urandom);
      value[BPP_BITS-1:0] = BPP_BITS'(bpp);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_ROW_PITCH, PITCH_BITS'(pitch));
      write_register(CSR_BYTES_PER_PIXEL, value);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_TICK, '1);
      send_line(0, 0, COORD_MAX, COORD_MAX, 24'hFFFFFF, 2);
      send_line(COORD_MAX, COORD_MAX, 0, 1000, 24'h000000, 2);
      send_line(500, 500, 500, 500, 24'hA5A5A5, 1);
      send_line(5, 7, 8, 7, 24'h123456, 5);
      send_line(3, 10, 1, 6, 24'hFEDCBA, 5);
      send_line(700, COORD_MAX, 700, 1020, 24'h5A5A5A, 4);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: configure(1, 2);
            2: configure(1024, 3);
            3: configure(2047, 3);
            4: configure(0, 0);
            5: configure($urandom_range(1, 1024), $urandom_range(1, 3));
            default: ;
         endcase
         while (items_sent < (phase + 1) * ITEM_TARGET / PHASES)
            random_line();
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
